/* sv/smwh_pkg.sv */
`default_nettype none

package smwh_pkg;

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_TMO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE_TMO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TMO = 2'd2;

  localparam logic [15:0] SELECT_TMO_RST  = 16'd500;
  localparam logic [15:0] STROBE_TMO_RST  = 16'd10;
  localparam logic [15:0] RELEASE_TMO_RST = 16'd5;

  // Session phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SELECT  = 2'd1;
  localparam logic [1:0] PH_STROBE  = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Command codes
  localparam logic [7:0] CMD_ADDR   = 8'h10;
  localparam logic [7:0] CMD_DATA_L = 8'h11;
  localparam logic [7:0] CMD_DATA_H = 8'h12;
  localparam logic [7:0] CMD_MASK_L = 8'h13;
  localparam logic [7:0] CMD_MASK_H = 8'h14;

  typedef struct packed {
    logic [15:0] select_tmo;
    logic [15:0] strobe_tmo;
    logic [15:0] release_tmo;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       select_pin;
    logic       strobe_pin;
    logic [7:0] command_code;
    logic [7:0] data_low;
    logic [7:0] data_high;
    logic [5:0] flag_bits;
    logic       unit_tick;
  } item_in_t;

  typedef struct packed {
    logic        ack_pin;
    logic        write_valid;
    logic [15:0] write_address;
    logic [31:0] write_mask;
    logic [31:0] write_data;
    logic        session_active;
    logic        timed_out;
  } item_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] wait_count;
    logic [31:0] held_mask;
    logic [31:0] held_data;
    logic [15:0] held_address;
    logic        ack_level;
  } sess_state_t;

endpackage

`default_nettype wire

/* sv/smwh_cfg.sv */
`default_nettype none

module smwh_cfg
  import smwh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.select_tmo  <= SELECT_TMO_RST;
      cfg_r.strobe_tmo  <= STROBE_TMO_RST;
      cfg_r.release_tmo <= RELEASE_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECT_TMO:  cfg_r.select_tmo  <= cfg_wdata;
        CFG_STROBE_TMO:  cfg_r.strobe_tmo  <= cfg_wdata;
        CFG_RELEASE_TMO: cfg_r.release_tmo <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/smwh_step.sv */
`default_nettype none

module smwh_step
  import smwh_pkg::*;
(
  input  wire sess_state_t st,
  input  wire item_in_t    item,
  input  wire cfg_t        cfg,
  output sess_state_t      st_nxt,
  output item_out_t        res
);

  logic [15:0] limit;
  logic [16:0] cnt_inc;
  logic        expire;
  logic [15:0] half;
  logic        wr;
  logic        tmo;

  assign half    = {item.data_high, item.data_low};
  assign cnt_inc = {1'b0, st.wait_count} + 17'd1;

  always_comb begin
    case (st.phase)
      PH_SELECT: limit = cfg.select_tmo;
      PH_STROBE: limit = cfg.strobe_tmo;
      default:   limit = cfg.release_tmo;
    endcase
  end

  // a zero limit expires on the first tick
  assign expire = item.unit_tick && (cnt_inc >= {1'b0, limit});

  always_comb begin
    st_nxt = st;
    wr     = 1'b0;
    tmo    = 1'b0;
    // shared wait step: bump or clear the tick count
    if (st.phase != PH_IDLE && item.unit_tick) begin
      st_nxt.wait_count = expire ? 16'd0 : cnt_inc[15:0];
    end
    case (st.phase)
      PH_IDLE: begin
        st_nxt.wait_count = st.wait_count;
        if (item.start_req) begin
          st_nxt.ack_level  = 1'b0;
          st_nxt.phase      = PH_SELECT;
          st_nxt.wait_count = 16'd0;
        end
      end
      PH_SELECT: begin
        if (item.select_pin) begin
          st_nxt.phase      = PH_STROBE;
          st_nxt.wait_count = 16'd0;
        end else if (expire) begin
          st_nxt.phase = PH_IDLE;
          tmo          = 1'b1;
        end
      end
      PH_STROBE: begin
        if (item.strobe_pin) begin
          case (item.command_code)
            CMD_MASK_L: st_nxt.held_mask[15:0]  = half;
            CMD_MASK_H: st_nxt.held_mask[31:16] = half;
            CMD_DATA_L: st_nxt.held_data[15:0]  = half;
            CMD_DATA_H: st_nxt.held_data[31:16] = half;
            CMD_ADDR: begin
              st_nxt.held_address = half;
              wr                  = !item.flag_bits[0];
            end
            default: ;
          endcase
          st_nxt.ack_level  = 1'b1;
          st_nxt.phase      = PH_RELEASE;
          st_nxt.wait_count = 16'd0;
        end else if (expire) begin
          st_nxt.phase = PH_IDLE;
          tmo          = 1'b1;
        end
      end
      default: begin
        if (!item.strobe_pin) begin
          st_nxt.ack_level  = 1'b0;
          st_nxt.phase      = PH_SELECT;
          st_nxt.wait_count = 16'd0;
        end else if (expire) begin
          st_nxt.phase = PH_IDLE;  // ack stays high
          tmo          = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.ack_pin        = st_nxt.ack_level;
    res.write_valid    = wr;
    res.write_address  = wr ? st_nxt.held_address : 16'd0;
    res.write_mask     = wr ? st_nxt.held_mask    : 32'd0;
    res.write_data     = wr ? st_nxt.held_data    : 32'd0;
    res.session_active = (st_nxt.phase != PH_IDLE);
    res.timed_out      = tmo;
  end

endmodule

`default_nettype wire

/* sv/sideband_masked_write_handshake_core.sv */
`default_nettype none

// Sideband masked-write handshake slave. Each input item is one sampled cycle
// of the partner's pins (select, strobe, command byte, two data bytes, flags)
// plus a timeout-unit tick and a start request; each item yields exactly one
// result item with the acknowledge level, an optional masked write request
// (address, 32-bit mask, 32-bit data) and session/timeout status. Items flow
// at one per clock unless the result stalls: an item sits in the input
// register, the session step logic runs in a single pass, and the result
// lands in the output register, so out_valid rises once it is registered.
// The rate is set by the session state update, registered as items advance.
// A stalled result holds the pipe; the input register still takes an item
// while empty or while the result register is empty or draining. Timeout
// registers (select, strobe, release; reset 500, 10 and 5 units) are written
// through cfg_*, by the user only while the block is idle (not enforced).

module sideband_masked_write_handshake_core
  import smwh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_wdata,

  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 in_start_req,
  input  wire logic                 in_select_pin,
  input  wire logic                 in_strobe_pin,
  input  wire logic [7:0]           in_command_code,
  input  wire logic [7:0]           in_data_low,
  input  wire logic [7:0]           in_data_high,
  input  wire logic [5:0]           in_flag_bits,
  input  wire logic                 in_unit_tick,

  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 out_ack_pin,
  output      logic                 out_write_valid,
  output      logic [15:0]          out_write_address,
  output      logic [31:0]          out_write_mask,
  output      logic [31:0]          out_write_data,
  output      logic                 out_session_active,
  output      logic                 out_timed_out
);

  cfg_t        cfg;
  item_in_t    item_r;
  logic        item_vld_r;
  logic        item_vld_nxt;
  item_out_t   res_r;
  item_out_t   res_nxt;
  logic        res_vld_r;
  logic        res_vld_nxt;
  sess_state_t st_r;
  sess_state_t st_nxt;
  logic        stage_go;
  logic        in_take;

  smwh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smwh_step u_step (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // the held item advances when the result register is free or being taken
  assign stage_go = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || stage_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_take) begin
      item_vld_nxt = 1'b1;
    end else if (stage_go) begin
      item_vld_nxt = 1'b0;
    end
    res_vld_nxt = res_vld_r;
    if (stage_go) begin
      res_vld_nxt = 1'b1;
    end else if (out_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      st_r       <= '0;  // idle, all holds clear, ack low
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
      if (stage_go) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.start_req    <= in_start_req;
      item_r.select_pin   <= in_select_pin;
      item_r.strobe_pin   <= in_strobe_pin;
      item_r.command_code <= in_command_code;
      item_r.data_low     <= in_data_low;
      item_r.data_high    <= in_data_high;
      item_r.flag_bits    <= in_flag_bits;
      item_r.unit_tick    <= in_unit_tick;
    end
    if (stage_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = res_vld_r;
  assign out_ack_pin        = res_r.ack_pin;
  assign out_write_valid    = res_r.write_valid;
  assign out_write_address  = res_r.write_address;
  assign out_write_mask     = res_r.write_mask;
  assign out_write_data     = res_r.write_data;
  assign out_session_active = res_r.session_active;
  assign out_timed_out      = res_r.timed_out;

  // a timeout always ends the session
  a_tmo_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> !out_session_active)
    else $error("timeout reported with session still active");

  // a write is only issued on a strobe, which raises ack and enters release
  a_wr_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_valid) |-> (out_ack_pin && out_session_active
      && !out_timed_out && st_r.phase == PH_RELEASE))
    else $error("write issued outside a strobe");

  // an advancing item always produces a result next cycle
  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go |=> out_valid)
    else $error("item advanced without a result");

  // reported activity matches the committed session phase
  a_active_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_session_active == (st_r.phase != PH_IDLE)))
    else $error("session_active disagrees with phase");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import smwh_pkg::*;

  // Unused register slot; writes to it must leave every timeout untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // A command byte outside the decoded set.
  localparam logic [7:0] CMD_UNKNOWN = 8'hff;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_req = 1'b0;
  logic                 in_select_pin = 1'b0;
  logic                 in_strobe_pin = 1'b0;
  logic [7:0]           in_command_code = '0;
  logic [7:0]           in_data_low = '0;
  logic [7:0]           in_data_high = '0;
  logic [5:0]           in_flag_bits = '0;
  logic                 in_unit_tick = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_ack_pin;
  logic                 out_write_valid;
  logic [15:0]          out_write_address;
  logic [31:0]          out_write_mask;
  logic [31:0]          out_write_data;
  logic                 out_session_active;
  logic                 out_timed_out;

  sideband_masked_write_handshake_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_select_pin     (in_select_pin),
    .in_strobe_pin     (in_strobe_pin),
    .in_command_code   (in_command_code),
    .in_data_low       (in_data_low),
    .in_data_high      (in_data_high),
    .in_flag_bits      (in_flag_bits),
    .in_unit_tick      (in_unit_tick),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ack_pin       (out_ack_pin),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_mask    (out_write_mask),
    .out_write_data    (out_write_data),
    .out_session_active(out_session_active),
    .out_timed_out     (out_timed_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Session predictor: shadow copy of the slave's phase, wait counter, held
  // words and acknowledge level, plus the three timeout registers.
  // ---------------------------------------------------------------------------
  logic [1:0]  sess_phase;
  logic [15:0] wait_units;
  logic [31:0] mask_word;
  logic [31:0] data_word;
  logic [15:0] addr_word;
  logic        ack_level_q;
  logic [15:0] tmo_select;
  logic [15:0] tmo_strobe;
  logic [15:0] tmo_release;

  item_out_t   exp_q[$];   // predicted result items, oldest first
  int unsigned mismatch_count = 0;

  // Test control, shared by the stimulus tasks and the result sink.
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned rx_hold_req = 0;

  // Counts one timeout unit; true once the wait hits its limit. A zero limit
  // expires on the very first tick.
  function automatic logic wait_expired(logic tick, logic [15:0] limit);
    logic [16:0] next_cnt;
    if (!tick) return 1'b0;
    next_cnt = {1'b0, wait_units} + 17'd1;
    if (next_cnt >= {1'b0, limit}) begin
      wait_units = '0;
      return 1'b1;
    end
    wait_units = next_cnt[15:0];
    return 1'b0;
  endfunction

  function automatic item_out_t predict_step(item_in_t it);
    item_out_t   res;
    logic [15:0] half;
    logic        wr;
    logic        tmo;
    half = {it.data_high, it.data_low};
    wr   = 1'b0;
    tmo  = 1'b0;
    case (sess_phase)
      PH_IDLE: begin
        // start only opens the select wait; the pins of this cycle are ignored
        if (it.start_req) begin
          ack_level_q = 1'b0;
          sess_phase  = PH_SELECT;
          wait_units  = '0;
        end
      end
      PH_SELECT: begin
        if (it.select_pin) begin
          sess_phase = PH_STROBE;
          wait_units = '0;
        end else if (wait_expired(it.unit_tick, tmo_select)) begin
          sess_phase = PH_IDLE;
          tmo        = 1'b1;
        end
      end
      PH_STROBE: begin
        if (it.strobe_pin) begin
          case (it.command_code)
            CMD_MASK_L: mask_word[15:0]  = half;
            CMD_MASK_H: mask_word[31:16] = half;
            CMD_DATA_L: data_word[15:0]  = half;
            CMD_DATA_H: data_word[31:16] = half;
            CMD_ADDR: begin
              addr_word = half;
              wr        = !it.flag_bits[0];
            end
            default: ;
          endcase
          ack_level_q = 1'b1;
          sess_phase  = PH_RELEASE;
          wait_units  = '0;
        end else if (wait_expired(it.unit_tick, tmo_strobe)) begin
          sess_phase = PH_IDLE;
          tmo        = 1'b1;
        end
      end
      default: begin
        if (!it.strobe_pin) begin
          ack_level_q = 1'b0;
          sess_phase  = PH_SELECT;
          wait_units  = '0;
        end else if (wait_expired(it.unit_tick, tmo_release)) begin
          // release timeout: ack is left high
          sess_phase = PH_IDLE;
          tmo        = 1'b1;
        end
      end
    endcase
    res.ack_pin        = ack_level_q;
    res.write_valid    = wr;
    res.write_address  = wr ? addr_word : '0;
    res.write_mask     = wr ? mask_word : '0;
    res.write_data     = wr ? data_word : '0;
    res.session_active = (sess_phase != PH_IDLE);
    res.timed_out      = tmo;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_in_t pin_item(logic start, logic sel, logic stb, logic [7:0] code,
                                        logic [7:0] lo, logic [7:0] hi, logic [5:0] flags,
                                        logic tick);
    item_in_t it;
    it.start_req    = start;
    it.select_pin   = sel;
    it.strobe_pin   = stb;
    it.command_code = code;
    it.data_low     = lo;
    it.data_high    = hi;
    it.flag_bits    = flags;
    it.unit_tick    = tick;
    return it;
  endfunction

  // Random pin sample. Unless it falls into the noise share, it is steered by
  // the predicted phase: idle mostly starts a session, and a strobe mostly
  // carries one of the decoded commands, so sessions build up real writes.
  function automatic item_in_t make_item(int unsigned noise_pct);
    item_in_t    it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it  = raw[$bits(item_in_t)-1:0];
    if ($urandom_range(0, 99) < noise_pct) return it;
    case (sess_phase)
      PH_IDLE: it.start_req = ($urandom_range(0, 9) != 0);
      PH_STROBE: begin
        case ($urandom_range(0, 5))
          0: it.command_code = CMD_ADDR;
          1: it.command_code = CMD_DATA_L;
          2: it.command_code = CMD_DATA_H;
          3: it.command_code = CMD_MASK_L;
          4: it.command_code = CMD_MASK_H;
          default: ;
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until accepted. valid stays high into the
  // next item unless a gap is drawn.
  task automatic send_item(item_in_t it);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_start_req    <= it.start_req;
    in_select_pin   <= it.select_pin;
    in_strobe_pin   <= it.strobe_pin;
    in_command_code <= it.command_code;
    in_data_low     <= it.data_low;
    in_data_high    <= it.data_high;
    in_flag_bits    <= it.flag_bits;
    in_unit_tick    <= it.unit_tick;
    do @(posedge clk); while (in_ready !== 1'b1);
    exp_q.push_back(predict_step(it));
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every predicted result has come out, then lets the
  // pipe settle so the block is quiet before any register write.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_SELECT_TMO:  tmo_select  = val;
      CFG_STROBE_TMO:  tmo_strobe  = val;
      CFG_RELEASE_TMO: tmo_release = val;
      default: ;
    endcase
  endtask

  // Writes all three timeouts plus junk to the unused slot.
  task automatic program_timeouts(logic [15:0] sel, logic [15:0] stb, logic [15:0] rel);
    write_reg(CFG_SELECT_TMO, sel);
    write_reg(CFG_STROBE_TMO, stb);
    write_reg(CFG_RELEASE_TMO, rel);
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // select, strobe with the command, strobe release
  task automatic run_command(logic [7:0] code, logic [7:0] lo, logic [7:0] hi,
                             logic [5:0] flags);
    send_item(pin_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    send_item(pin_item(1'b0, 1'b0, 1'b1, code, lo, hi, flags, 1'b0));
    send_item(pin_item(1'b0, 1'b1, 1'b0, ~code, ~lo, ~hi, ~flags, 1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timeouts, no ticks in a session: every command, byte extremes, and
  // the 0xff00ffff mask built from two halves.
  task automatic test_commands();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_item(pin_item(1'b0, 1'b1, 1'b1, CMD_ADDR, 8'hff, 8'hff, 6'h00, 1'b1));
    // start cycle: pins are not looked at
    send_item(pin_item(1'b1, 1'b1, 1'b1, CMD_ADDR, 8'h00, 8'h00, 6'h00, 1'b0));
    // start while busy is ignored
    send_item(pin_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h3f, 1'b0));
    run_command(CMD_MASK_L, 8'hff, 8'hff, 6'h00);
    run_command(CMD_MASK_H, 8'h00, 8'hff, 6'h00);
    run_command(CMD_DATA_L, 8'ha5, 8'h5a, 6'h3f);
    run_command(CMD_DATA_H, 8'hff, 8'h00, 6'h00);
    run_command(CMD_ADDR, 8'hff, 8'hff, 6'h3e);
    // address with flag bit 0 set: stored, no write
    run_command(CMD_ADDR, 8'h34, 8'h12, 6'h01);
    run_command(CMD_UNKNOWN, 8'h00, 8'h00, 6'h00);
    wait_results();
  endtask

  // Zero timeouts: each wait ends on its first tick; the release timeout
  // leaves ack high until the next start.
  task automatic test_timeouts();
    program_timeouts(16'd0, 16'd0, 16'd0);
    send_item(pin_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1));
    send_item(pin_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    send_item(pin_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1));
    send_item(pin_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    send_item(pin_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1));
    send_item(pin_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1));
    send_item(pin_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    send_item(pin_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    send_item(pin_item(1'b0, 1'b0, 1'b1, CMD_DATA_L, 8'h11, 8'h22, 6'h00, 1'b1));
    send_item(pin_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1));
    send_item(pin_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0));
    wait_results();
  endtask

  task automatic test_random(int unsigned n, logic [15:0] sel, logic [15:0] stb,
                             logic [15:0] rel, bit tx_idle, bit rx_idle);
    program_timeouts(sel, stb, rel);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    repeat (n) send_item(make_item(10));
    wait_results();
  endtask

  // Receiver goes deaf for a long stretch while items keep coming, so the
  // block fills and drops in_ready.
  task automatic test_backpressure();
    program_timeouts(16'd3, 16'd3, 16'd3);
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 150;
    repeat (40) send_item(make_item(10));
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Result sink: random stalls when enabled, long holds on request.
  initial begin : result_sink
    int unsigned n;
    @(posedge clk);
    forever begin
      if (rx_hold_req != 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    item_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (exp_q.size() == 0) begin
        $error("result item with no prediction pending");
        mismatch_count++;
      end else begin
        want = exp_q.pop_front();
        check_field("ack_pin", 32'(want.ack_pin), 32'(out_ack_pin));
        check_field("write_valid", 32'(want.write_valid), 32'(out_write_valid));
        check_field("write_address", 32'(want.write_address), 32'(out_write_address));
        check_field("write_mask", want.write_mask, out_write_mask);
        check_field("write_data", want.write_data, out_write_data);
        check_field("session_active", 32'(want.session_active), 32'(out_session_active));
        check_field("timed_out", 32'(want.timed_out), 32'(out_timed_out));
      end
    end
  end

  // Watchdog: too long without any handshake on either side means a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    sess_phase  = PH_IDLE;
    wait_units  = '0;
    mask_word   = '0;
    data_word   = '0;
    addr_word   = '0;
    ack_level_q = 1'b0;
    tmo_select  = SELECT_TMO_RST;
    tmo_strobe  = STROBE_TMO_RST;
    tmo_release = RELEASE_TMO_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands();
    test_timeouts();
    test_random(200, 16'd1, 16'd1, 16'd1, 1'b1, 1'b1);
    test_random(150, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0);
    test_random(200, 16'($urandom_range(2, 6)), 16'($urandom_range(2, 6)),
                16'($urandom_range(2, 6)), 1'b1, 1'b1);
    test_random(150, 16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
                16'($urandom_range(1, 20)), 1'b1, 1'b0);
    test_random(150, SELECT_TMO_RST, STROBE_TMO_RST, RELEASE_TMO_RST, 1'b0, 1'b1);
    test_backpressure();
    test_random(120, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 4)), 1'b1, 1'b1);

    if (mismatch_count == 0 && exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
